// ===== rtl/core/clwseq_pkg.sv =====
// shared types and constants of the character lcd write sequencer
package clwseq_pkg;

  // request type codes
  localparam logic [2:0] REQ_DATA   = 3'd0;
  localparam logic [2:0] REQ_CMD    = 3'd1;
  localparam logic [2:0] REQ_CURSOR = 3'd2;
  localparam logic [2:0] REQ_NUMBER = 3'd3;
  localparam logic [2:0] REQ_GLYPH  = 3'd4;

  // lcd command bits and character codes
  localparam logic [7:0] CGRAM_SET  = 8'h40;
  localparam logic       DDRAM_SET  = 1'b1;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // divide by ten as multiply by reciprocal, exact for any 32-bit value
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // glyph run steps
  localparam logic [3:0] STEP_CGRAM     = 4'd0;
  localparam logic [3:0] STEP_ROW_FIRST = 4'd1;
  localparam logic [3:0] STEP_ROW_LAST  = 4'd8;
  localparam logic [3:0] STEP_CURSOR    = 4'd9;
  localparam logic [3:0] STEP_SLOT      = 4'd10;

  // kind of job handed from front to back
  typedef enum logic [1:0] {
    K_SINGLE = 2'd0,
    K_NUMBER = 2'd1,
    K_GLYPH  = 2'd2
  } kind_e;

  // classified job, digits travel beside it
  typedef struct packed {
    kind_e       kind;
    logic        rs;
    logic [7:0]  wbyte;
    logic        bad;
    logic [2:0]  slot;
    logic [7:0]  addr;
    logic [63:0] rows;
  } job_t;

endpackage

// ===== rtl/core/clwseq_front.sv =====
// front end: accepts requests, classifies them and converts numbers to digits
module clwseq_front #(
  parameter int MAX_DIGITS = 10,
  parameter int DW         = MAX_DIGITS * 4,
  parameter int CW         = $clog2(MAX_DIGITS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          req_type_i,
  input  logic [7:0]          byte_value_i,
  input  logic [1:0]          row_i,
  input  logic [5:0]          column_i,
  input  logic [31:0]         number_i,
  input  logic [2:0]          glyph_slot_i,
  input  logic [63:0]         glyph_rows_i,
  input  logic                full_i,
  output logic                push_o,
  output clwseq_pkg::job_t    job_o,
  output logic [DW-1:0]       digits_o,
  output logic [CW-1:0]       count_o
);
  import clwseq_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_DIG  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_e;

  fstate_e        state_q, state_d;
  job_t           job_q, job_d;
  logic [31:0]    val_q, val_d;
  logic [63:0]    prod_q, prod_d;
  logic [DW-1:0]  digits_q, digits_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  logic [28:0]    quot;
  logic [3:0]     quot_ten_lo;
  logic [3:0]     rem;
  logic [CW-1:0]  cnt_inc;

  // quotient and remainder of the current value by ten
  assign quot        = prod_q[63:RECIP_SHIFT];
  assign quot_ten_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign rem         = val_q[3:0] - quot_ten_lo;
  assign cnt_inc     = cnt_q + CW'(1);

  // request classification and digit loop
  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    val_d    = val_q;
    prod_d   = prod_q;
    digits_d = digits_q;
    cnt_d    = cnt_q;
    unique case (state_q)
      F_IDLE: begin
        if (start) begin
          job_d.kind  = K_SINGLE;
          job_d.rs    = 1'b0;
          job_d.wbyte = byte_value_i;
          job_d.bad   = 1'b0;
          job_d.slot  = glyph_slot_i;
          job_d.addr  = {DDRAM_SET, row_i[0], column_i};
          job_d.rows  = glyph_rows_i;
          state_d     = F_PUSH;
          case (req_type_i)
            REQ_DATA: job_d.rs = 1'b1;
            REQ_CMD: ;
            REQ_CURSOR: begin
              job_d.wbyte = row_i[1] ? 8'h00 : {DDRAM_SET, row_i[0], column_i};
              job_d.bad   = row_i[1];
            end
            REQ_NUMBER: begin
              job_d.kind = K_NUMBER;
              val_d      = number_i;
              cnt_d      = '0;
              digits_d   = '0;
              state_d    = F_MUL;
            end
            REQ_GLYPH: begin
              if (row_i[1]) begin
                job_d.wbyte = 8'h00;
                job_d.bad   = 1'b1;
              end else begin
                job_d.kind = K_GLYPH;
              end
            end
            default: state_d = F_IDLE;
          endcase
        end
      end
      F_MUL: begin
        prod_d  = 64'(val_q) * 64'(RECIP_TEN);
        state_d = F_DIG;
      end
      F_DIG: begin
        digits_d = (digits_q << 4) | DW'(rem);
        cnt_d    = cnt_inc;
        val_d    = {3'b000, quot};
        if (quot == '0 || cnt_inc == CW'(MAX_DIGITS)) begin
          state_d = F_PUSH;
        end else begin
          state_d = F_MUL;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    val_q    <= val_d;
    prod_q   <= prod_d;
    digits_q <= digits_d;
    cnt_q    <= cnt_d;
  end

  assign busy     = (state_q != F_IDLE);
  assign push_o   = (state_q == F_PUSH) && !full_i;
  assign job_o    = job_q;
  assign digits_o = digits_q;
  assign count_o  = cnt_q;

endmodule

// ===== rtl/core/clwseq_queue.sv =====
// two-entry job queue between front and back
module clwseq_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         avail_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   fill_q;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (fill_q == 2'd2);
  assign avail_o = (fill_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

// ===== rtl/core/clwseq_back.sv =====
// back end: expands one job into its run of bus writes
module clwseq_back #(
  parameter int MAX_DIGITS = 10,
  parameter int DW         = MAX_DIGITS * 4,
  parameter int CW         = $clog2(MAX_DIGITS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  output logic              pop_o,
  input  clwseq_pkg::job_t  job_i,
  input  logic [DW-1:0]     digits_i,
  input  logic [CW-1:0]     count_i,
  output logic              out_valid_o,
  output logic              reg_select_o,
  output logic [7:0]        bus_byte_o,
  output logic              bad_row_o,
  output logic              last_o
);
  import clwseq_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } bstate_e;

  bstate_e        state_q, state_d;
  job_t           job_q, job_d;
  logic [DW-1:0]  digits_q, digits_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [3:0]     step_q, step_d;

  logic           valid_q, valid_d;
  logic           rs_q, rs_d;
  logic [7:0]     byte_q, byte_d;
  logic           bad_q, bad_d;
  logic           last_q, last_d;

  assign pop_o = (state_q == B_IDLE) && avail_i;

  // one write per cycle while running
  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    digits_d = digits_q;
    cnt_d    = cnt_q;
    step_d   = step_q;
    valid_d  = 1'b0;
    rs_d     = rs_q;
    byte_d   = byte_q;
    bad_d    = 1'b0;
    last_d   = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (avail_i) begin
          job_d    = job_i;
          digits_d = digits_i;
          cnt_d    = count_i;
          step_d   = STEP_CGRAM;
          state_d  = B_RUN;
        end
      end
      B_RUN: begin
        valid_d = 1'b1;
        case (job_q.kind)
          K_SINGLE: begin
            rs_d    = job_q.rs;
            byte_d  = job_q.wbyte;
            bad_d   = job_q.bad;
            last_d  = 1'b1;
            state_d = B_IDLE;
          end
          K_NUMBER: begin
            // most significant digit sits in the low nibble
            rs_d     = 1'b1;
            byte_d   = ASCII_ZERO | {4'h0, digits_q[3:0]};
            digits_d = digits_q >> 4;
            cnt_d    = cnt_q - CW'(1);
            if (cnt_q == CW'(1)) begin
              last_d  = 1'b1;
              state_d = B_IDLE;
            end
          end
          default: begin
            step_d = step_q + 4'd1;
            case (step_q) inside
              STEP_CGRAM: begin
                rs_d   = 1'b0;
                byte_d = CGRAM_SET | {2'b00, job_q.slot, 3'b000};
              end
              [STEP_ROW_FIRST:STEP_ROW_LAST]: begin
                rs_d       = 1'b1;
                byte_d     = job_q.rows[7:0];
                job_d.rows = job_q.rows >> 8;
              end
              STEP_CURSOR: begin
                rs_d   = 1'b0;
                byte_d = job_q.addr;
              end
              default: begin
                rs_d    = 1'b1;
                byte_d  = {5'b00000, job_q.slot};
                last_d  = 1'b1;
                state_d = B_IDLE;
              end
            endcase
          end
        endcase
      end
      default: state_d = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    digits_q <= digits_d;
    cnt_q    <= cnt_d;
    step_q   <= step_d;
    rs_q     <= rs_d;
    byte_q   <= byte_d;
    bad_q    <= bad_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = valid_q;
  assign reg_select_o = rs_q;
  assign bus_byte_o   = byte_q;
  assign bad_row_o    = bad_q;
  assign last_o       = last_q;

endmodule

// ===== rtl/core/char_lcd_write_sequencer_core.sv =====
// top level of the character lcd write sequencer
//
// A request is taken at a rising edge with start high and busy low. Its
// fields select one of: data byte, command byte, cursor move, decimal
// number or custom glyph. Each resulting bus write appears for exactly one
// cycle with out_valid_o high; last_o marks the final write of a run and
// bad_row_o marks the single error write of a cursor or glyph request
// with row above 1. Unused request types produce no writes.
// A single write passes the front end push state, the job queue, the
// emitter run state and its output registers; a glyph run is 11 writes
// on consecutive cycles. A number takes a reciprocal multiply step, then a
// remainder step, per digit in the front end, then one write per cycle per
// digit. A two-entry job queue splits the front end and the write emitter,
// so a new request is taken while earlier runs are still being written;
// busy stays high while a number converts and until its job is queued.
// Reset clears the front end, queue and emitter; nothing is in flight after.
// Writes cannot be held off by the receiver.
module char_lcd_write_sequencer_core #(
  parameter int MAX_DIGITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  byte_value_i,
  input  logic [1:0]  row_i,
  input  logic [5:0]  column_i,
  input  logic [31:0] number_i,
  input  logic [2:0]  glyph_slot_i,
  input  logic [63:0] glyph_rows_i,
  output logic        out_valid_o,
  output logic        reg_select_o,
  output logic [7:0]  bus_byte_o,
  output logic        bad_row_o,
  output logic        last_o
);
  import clwseq_pkg::*;

  localparam int DW = MAX_DIGITS * 4;
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int JW = $bits(job_t);
  localparam int QW = JW + DW + CW;

  logic           push, full, pop, avail;
  job_t           front_job, back_job;
  logic [DW-1:0]  front_digits, back_digits;
  logic [CW-1:0]  front_count, back_count;
  logic [QW-1:0]  q_wdata, q_rdata;

  // request intake and classification
  clwseq_front #(
    .MAX_DIGITS(MAX_DIGITS),
    .DW(DW),
    .CW(CW)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_type_i(req_type_i),
    .byte_value_i(byte_value_i),
    .row_i(row_i),
    .column_i(column_i),
    .number_i(number_i),
    .glyph_slot_i(glyph_slot_i),
    .glyph_rows_i(glyph_rows_i),
    .full_i(full),
    .push_o(push),
    .job_o(front_job),
    .digits_o(front_digits),
    .count_o(front_count)
  );

  // job queue
  assign q_wdata = {front_job, front_digits, front_count};

  clwseq_queue #(
    .W(QW)
  ) u_queue (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(q_wdata),
    .full_o(full),
    .pop_i(pop),
    .avail_o(avail),
    .data_o(q_rdata)
  );

  assign back_job    = job_t'(q_rdata[QW-1 -: JW]);
  assign back_digits = q_rdata[CW +: DW];
  assign back_count  = q_rdata[CW-1:0];

  // write emitter
  clwseq_back #(
    .MAX_DIGITS(MAX_DIGITS),
    .DW(DW),
    .CW(CW)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .avail_i(avail),
    .pop_o(pop),
    .job_i(back_job),
    .digits_i(back_digits),
    .count_i(back_count),
    .out_valid_o(out_valid_o),
    .reg_select_o(reg_select_o),
    .bus_byte_o(bus_byte_o),
    .bad_row_o(bad_row_o),
    .last_o(last_o)
  );

  // the error write is always a lone command write of zero ending its run
  a_bad_row_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_row_o) |-> (last_o && !reg_select_o && bus_byte_o == 8'h00))
    else $error("error write malformed");

  // the queue never takes a job while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("push into full queue");

  // a job is popped only when one is waiting
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> avail)
    else $error("pop from empty queue");

  // a transfer of a known request kind keeps the front end busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i <= REQ_GLYPH) |=> busy)
    else $error("front end idle after accepting a request");

endmodule
